/* hdl/itf_pkg.sv */
package itf_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned WIDTH_W = 6;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [CMD_W-1:0] CMD_OCT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SDEC = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UDEC = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HEXL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HEXU = 3'd4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER = 8'h61;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic load;
    logic mul;
    logic dig;
    logic prep;
    logic emit_sign;
    logic emit_pad;
    logic emit_dig;
  } itf_cmd_t;

  typedef struct packed {
    logic in_dec;
    logic dec;
    logic q_zero;
    logic neg;
    logic pad_zero;
    logic idx_zero;
    logic out_free;
  } itf_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_UPPER : CH_LOWER;
    if (d > 4'd9) begin
      return base + {4'd0, d} - 8'd10;
    end
    return CH_ZERO + {4'd0, d};
  endfunction

endpackage

/* hdl/integer_to_text_formatter.sv */
// Channel  Direction  Handshake            Word
// in_      input      in_valid / in_stall  in_cmd, in_value, in_width, in_zero_pad
// out_     output     out_valid/out_stall  out_char, out_last
//
// A decimal digit passes through the multiply state before the digit state, as the
// reciprocal multiplier is registered before the remainder is formed; octal and hex
// digits need only the digit state. Each item passes through load, the digit states,
// a prep state and a sign state that is always visited, even with no sign, and then
// emits its pad characters and its digits, waiting while the output is not free.
// Reset is synchronous and active low; the digit store needs no clearing.
// A stalled output holds the character stage; the next item is taken while
// the final character of the previous one still waits.
module integer_to_text_formatter #(
  parameter int unsigned MAX_WIDTH = 32,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [itf_pkg::CMD_W-1:0]     in_cmd,
  input  logic [itf_pkg::VALUE_W-1:0]   in_value,
  input  logic [itf_pkg::WIDTH_W-1:0]   in_width,
  input  logic                          in_zero_pad,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [itf_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last
);
  import itf_pkg::*;

  itf_cmd_t cmd;
  itf_sts_t sts;

  itf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itf_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_cmd      (in_cmd),
    .in_value    (in_value),
    .in_width    (in_width),
    .in_zero_pad (in_zero_pad),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .out_last    (out_last)
  );

`ifndef SYNTHESIS
  a_emit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_sign, cmd.emit_pad, cmd.emit_dig}))
    else $error("more than one character source selected");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sign || cmd.emit_pad || cmd.emit_dig) |-> sts.out_free)
    else $error("character written over a waiting word");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> cmd.load)
    else $error("input word accepted without a load");

  a_dec_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.dig && sts.dec) |-> $past(cmd.mul))
    else $error("decimal digit formed without a fresh product");
`endif

endmodule

/* hdl/itf_ctrl.sv */
module itf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  itf_pkg::itf_sts_t sts,
  output itf_pkg::itf_cmd_t cmd
);
  import itf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIG,
    ST_PREP,
    ST_SIGN,
    ST_PAD,
    ST_DIGS
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.in_dec ? ST_MUL : ST_DIG;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIG;
      end
      ST_DIG: begin
        cmd.dig = 1'b1;
        if (sts.q_zero) begin
          state_nxt = ST_PREP;
        end else begin
          state_nxt = sts.dec ? ST_MUL : ST_DIG;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_SIGN;
      end
      ST_SIGN: begin
        if (!sts.neg) begin
          state_nxt = ST_PAD;
        end else if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_PAD;
        end
      end
      ST_PAD: begin
        if (sts.pad_zero) begin
          state_nxt = ST_DIGS;
        end else if (sts.out_free) begin
          cmd.emit_pad = 1'b1;
        end
      end
      ST_DIGS: begin
        if (sts.out_free) begin
          cmd.emit_dig = 1'b1;
          if (sts.idx_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

/* hdl/itf_dp.sv */
module itf_dp #(
  parameter int unsigned MAX_WIDTH = 32,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [itf_pkg::CMD_W-1:0]     in_cmd,
  input  logic [itf_pkg::VALUE_W-1:0]   in_value,
  input  logic [itf_pkg::WIDTH_W-1:0]   in_width,
  input  logic                          in_zero_pad,
  input  itf_pkg::itf_cmd_t             cmd,
  output itf_pkg::itf_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [itf_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last
);
  import itf_pkg::*;

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned IDX_W = $clog2(MAX_WIDTH);
  localparam logic [W-1:0] RECIP = W'(((64'd1 << (W + 3)) + 64'd9) / 64'd10);

  typedef enum logic [1:0] {
    RAD_OCT,
    RAD_DEC,
    RAD_HEX
  } radix_t;

  logic [CHAR_W-1:0] mem [MAX_WIDTH];

  logic [W-1:0]       rem_r,    rem_nxt;
  logic [2*W-1:0]     prod_r,   prod_nxt;
  radix_t             rad_r,    rad_nxt;
  logic               upper_r,  upper_nxt;
  logic               neg_r,    neg_nxt;
  logic               zpad_r,   zpad_nxt;
  logic [WIDTH_W-1:0] wid_r,    wid_nxt;
  logic [CNT_W-1:0]   count_r,  count_nxt;
  logic [WIDTH_W-1:0] pad_r,    pad_nxt;
  logic [IDX_W-1:0]   idx_r,    idx_nxt;
  logic [CHAR_W-1:0]  rd_data_r;
  logic               ovld_r,   ovld_nxt;
  logic [CHAR_W-1:0]  ochar_r,  ochar_nxt;
  logic               olast_r,  olast_nxt;

  logic               in_dec;
  radix_t             in_rad;
  logic               in_upper;
  logic               in_neg;
  logic [W-1:0]       in_word;
  logic [W-1:0]       quot;
  logic [3:0]         dig;
  logic [3:0]         tenq_lo;
  logic [CHAR_W-1:0]  dig_ch;
  logic               out_free;
  logic               do_write;
  logic [WIDTH_W-1:0] cnt_ext;

  always_comb begin
    in_rad   = RAD_DEC;
    in_upper = 1'b0;
    case (in_cmd)
      CMD_OCT:  in_rad = RAD_OCT;
      CMD_SDEC: in_rad = RAD_DEC;
      CMD_UDEC: in_rad = RAD_DEC;
      CMD_HEXL: in_rad = RAD_HEX;
      CMD_HEXU: begin
        in_rad   = RAD_HEX;
        in_upper = 1'b1;
      end
      default:  in_rad = RAD_DEC;
    endcase
  end

  assign in_dec  = (in_rad == RAD_DEC);
  assign in_neg  = (in_cmd == CMD_SDEC) && in_value[W-1];
  assign in_word = in_neg ? (~in_value[W-1:0] + W'(1)) : in_value[W-1:0];

  always_comb begin
    tenq_lo = 4'd0;
    case (rad_r)
      RAD_OCT: begin
        quot = W'(rem_r >> 3);
        dig  = {1'b0, rem_r[2:0]};
      end
      RAD_HEX: begin
        quot = W'(rem_r >> 4);
        dig  = rem_r[3:0];
      end
      default: begin
        quot    = W'(prod_r[2*W-1:W+3]);
        tenq_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
        dig     = rem_r[3:0] - tenq_lo;
      end
    endcase
  end

  assign dig_ch   = digit_char(dig, upper_r);
  assign out_free = !ovld_r || !out_stall;
  assign do_write = cmd.dig && (count_r < CNT_W'(MAX_WIDTH));
  assign cnt_ext  = WIDTH_W'(count_r);

  always_comb begin
    rem_nxt   = rem_r;
    prod_nxt  = prod_r;
    rad_nxt   = rad_r;
    upper_nxt = upper_r;
    neg_nxt   = neg_r;
    zpad_nxt  = zpad_r;
    wid_nxt   = wid_r;
    count_nxt = count_r;
    pad_nxt   = pad_r;
    idx_nxt   = idx_r;
    ovld_nxt  = ovld_r && out_stall;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;

    if (cmd.load) begin
      rem_nxt   = in_word;
      rad_nxt   = in_rad;
      upper_nxt = in_upper;
      neg_nxt   = in_neg;
      zpad_nxt  = in_zero_pad;
      wid_nxt   = (in_width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : in_width;
      count_nxt = '0;
    end
    if (cmd.mul) begin
      prod_nxt = rem_r * RECIP;
    end
    if (cmd.dig) begin
      rem_nxt = quot;
      if (do_write) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
    if (cmd.prep) begin
      pad_nxt = (wid_r > cnt_ext) ? (wid_r - cnt_ext) : '0;
      idx_nxt = IDX_W'(count_r - CNT_W'(1));
    end
    if (cmd.emit_sign) begin
      ovld_nxt  = 1'b1;
      ochar_nxt = CH_MINUS;
      olast_nxt = 1'b0;
    end
    if (cmd.emit_pad) begin
      ovld_nxt  = 1'b1;
      ochar_nxt = zpad_r ? CH_ZERO : CH_SPACE;
      olast_nxt = 1'b0;
      pad_nxt   = pad_r - WIDTH_W'(1);
    end
    if (cmd.emit_dig) begin
      ovld_nxt  = 1'b1;
      ochar_nxt = rd_data_r;
      olast_nxt = (idx_r == '0);
      idx_nxt   = idx_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r  <= 1'b0;
      rem_r   <= '0;
      count_r <= '0;
      rad_r   <= RAD_DEC;
    end else begin
      ovld_r  <= ovld_nxt;
      rem_r   <= rem_nxt;
      count_r <= count_nxt;
      rad_r   <= rad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    upper_r <= upper_nxt;
    neg_r   <= neg_nxt;
    zpad_r  <= zpad_nxt;
    wid_r   <= wid_nxt;
    pad_r   <= pad_nxt;
    idx_r   <= idx_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[count_r[IDX_W-1:0]] <= dig_ch;
    end
    rd_data_r <= mem[idx_nxt];
  end

  assign sts.in_dec   = in_dec;
  assign sts.dec      = (rad_r == RAD_DEC);
  assign sts.q_zero   = (quot == '0);
  assign sts.neg      = neg_r;
  assign sts.pad_zero = (pad_r == '0);
  assign sts.idx_zero = (idx_r == '0);
  assign sts.out_free = out_free;

  assign out_valid = ovld_r;
  assign out_char  = ochar_r;
  assign out_last  = olast_r;

endmodule
